### design/bsp_pkg.sv
package bsp_pkg;

    // Source frame geometry and fraction precision
    localparam int SRC_WIDTH  = 640;
    localparam int SRC_HEIGHT = 400;
    localparam int FRAC_BITS  = 8;

    // Field widths of the stream items and registers
    localparam int CMD_W    = 1;
    localparam int COLUMN_W = 10;
    localparam int PIX_W    = 24;
    localparam int XY_W     = 12;
    localparam int DIM_W    = 13;
    localparam int FMT_W    = 2;
    localparam int ROW_W    = 9;
    localparam int WORD_W   = 32;

    localparam int ADDR_W = $clog2(SRC_WIDTH);

    // Stream packing (tdata / tuser bit positions)
    localparam int S_TDATA_W  = 64;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 48;
    localparam int TD_COL_LSB = 0;
    localparam int TD_PIX_LSB = TD_COL_LSB + COLUMN_W;
    localparam int TD_OX_LSB  = TD_PIX_LSB + PIX_W;
    localparam int TD_OY_LSB  = TD_OX_LSB + XY_W;
    localparam int TU_CMD     = 0;
    localparam int TU_SEL     = 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    // Scale division: ((SRC-1) << FRAC_BITS) / size
    localparam int NUM_X   = (SRC_WIDTH - 1) << FRAC_BITS;
    localparam int NUM_Y   = (SRC_HEIGHT - 1) << FRAC_BITS;
    localparam int NUM_MAX = (NUM_X > NUM_Y) ? NUM_X : NUM_Y;
    localparam int DIV_W   = $clog2(NUM_MAX + 1);
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Register reset values
    localparam int OUT_WIDTH_RESET  = 640;
    localparam int OUT_HEIGHT_RESET = 400;
    localparam int SX_RESET = NUM_X / OUT_WIDTH_RESET;
    localparam int SY_RESET = NUM_Y / OUT_HEIGHT_RESET;

    // Colour channel masks
    localparam logic [WORD_W-1:0] MASK_RB = 32'h00FF_00FF;
    localparam logic [WORD_W-1:0] MASK_G  = 32'h0000_FF00;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;  // power of two
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 1'b0,
        CMD_REQUEST = 1'b1
    } t_cmd;

    typedef enum logic [FMT_W-1:0] {
        FMT_ARGB8888 = 2'd0,
        FMT_RGB888   = 2'd1,
        FMT_RGB565   = 2'd2,
        FMT_RGB555   = 2'd3
    } t_pix_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUT_WIDTH    = 2'd0,
        CFG_OUT_HEIGHT   = 2'd1,
        CFG_PIXEL_FORMAT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_X,
        DIV_Y
    } t_div_state;

    // Classified item: col carries the load column or the request's ix
    typedef struct packed {
        t_cmd                 cmd;
        logic                 sel;
        logic [ADDR_W-1:0]    col;
        logic [PIX_W-1:0]     pix;
        logic [FRAC_BITS-1:0] ex;
        logic [FRAC_BITS-1:0] ey;
        logic [ROW_W-1:0]     iy;
    } t_item;

endpackage

### design/bsp_ram.sv
module bsp_ram
    #(
        parameter int WIDTH = 24,
        parameter int DEPTH = 640
    )
    (
        input  logic                     i_clk,
        input  logic                     i_we,
        input  logic [$clog2(DEPTH)-1:0] i_waddr,
        input  logic [WIDTH-1:0]         i_wdata,
        input  logic                     i_re,
        input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
        input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
        output logic [WIDTH-1:0]         o_rdata_a,
        output logic [WIDTH-1:0]         o_rdata_b
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // One write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### design/bsp_fifo.sv
module bsp_fifo
    import bsp_pkg::*;
    (
        input  logic  i_clk,
        input  logic  i_rst_n,
        input  logic  i_push,
        input  t_item i_data,
        output logic  o_full,
        input  logic  i_pop,
        output t_item o_data,
        output logic  o_empty
    );

    t_item                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  push;
    logic                  pop;

    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign push    = i_push && !o_full;
    assign pop     = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + FIFO_CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - FIFO_CNT_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### design/bsp_front.sv
module bsp_front
    import bsp_pkg::*;
    (
        input  logic                  i_clk,
        input  logic                  i_rst_n,
        // item input
        input  logic                  i_valid,
        output logic                  o_ready,
        input  logic                  i_cmd,
        input  logic                  i_sel,
        input  logic [COLUMN_W-1:0]   i_col,
        input  logic [PIX_W-1:0]      i_pix,
        input  logic [XY_W-1:0]       i_ox,
        input  logic [XY_W-1:0]       i_oy,
        // configuration writes
        input  logic                  i_cfg_valid,
        output logic                  o_cfg_ready,
        input  logic [CFG_IDX_W-1:0]  i_cfg_index,
        input  logic [CFG_DATA_W-1:0] i_cfg_data,
        // towards the queue
        output logic                  o_push,
        output t_item                 o_item,
        input  logic                  i_full,
        output t_pix_fmt              o_fmt
    );

    t_div_state           r_state, n_state;
    logic [DIM_W-1:0]     r_out_width, n_out_width;
    logic [DIM_W-1:0]     r_out_height, n_out_height;
    t_pix_fmt             r_fmt, n_fmt;
    logic [DIV_W-1:0]     r_sx, n_sx;
    logic [DIV_W-1:0]     r_sy, n_sy;
    logic [DIV_W-1:0]     r_q, n_q;
    logic [DIM_W-1:0]     r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    logic                 r_f_valid;
    t_item                r_f_item;

    logic [DIM_W-1:0]     w_eff, h_eff, w_m1, h_m1, den;
    logic [DIM_W:0]       rem_sh, rem_sub;
    logic                 fits;
    logic [DIM_W-1:0]     rem_nx;
    logic [DIV_W-1:0]     q_nx;
    logic                 cfg_fire;
    logic                 accept;
    logic [XY_W-1:0]      ox_c, oy_c;
    logic [XY_W+DIV_W-1:0] prod_x, prod_y;
    t_item                n_item;
    logic                 keep;

    // Zero size behaves as one
    assign w_eff = (r_out_width == '0) ? DIM_W'(1) : r_out_width;
    assign h_eff = (r_out_height == '0) ? DIM_W'(1) : r_out_height;
    assign w_m1  = w_eff - DIM_W'(1);
    assign h_m1  = h_eff - DIM_W'(1);

    assign o_cfg_ready = (r_state == DIV_IDLE);
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign o_fmt       = r_fmt;

    // Restoring divider step, one quotient bit a cycle
    assign den     = (r_state == DIV_Y) ? h_eff : w_eff;
    assign rem_sh  = {r_rem, r_q[DIV_W-1]};
    assign fits    = (rem_sh >= {1'b0, den});
    assign rem_sub = rem_sh - {1'b0, den};
    assign rem_nx  = fits ? rem_sub[DIM_W-1:0] : rem_sh[DIM_W-1:0];
    assign q_nx    = {r_q[DIV_W-2:0], fits};

    // Register writes and scale recompute sequencing
    always_comb begin
        n_state      = r_state;
        n_out_width  = r_out_width;
        n_out_height = r_out_height;
        n_fmt        = r_fmt;
        n_sx         = r_sx;
        n_sy         = r_sy;
        n_q          = r_q;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        unique case (r_state)
            DIV_IDLE: begin
                if (cfg_fire) begin
                    unique case (t_cfg_idx'(i_cfg_index))
                        CFG_OUT_WIDTH: begin
                            n_out_width = i_cfg_data;
                            n_state     = DIV_X;
                        end
                        CFG_OUT_HEIGHT: begin
                            n_out_height = i_cfg_data;
                            n_state      = DIV_X;
                        end
                        CFG_PIXEL_FORMAT: begin
                            n_fmt = t_pix_fmt'(i_cfg_data[FMT_W-1:0]);
                        end
                        default: ;
                    endcase
                    n_q   = DIV_W'(NUM_X);
                    n_rem = '0;
                    n_cnt = '0;
                end
            end
            DIV_X: begin
                n_q   = q_nx;
                n_rem = rem_nx;
                n_cnt = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    n_sx    = q_nx;
                    n_q     = DIV_W'(NUM_Y);
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = DIV_Y;
                end
            end
            DIV_Y: begin
                n_q   = q_nx;
                n_rem = rem_nx;
                n_cnt = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    n_sy    = q_nx;
                    n_state = DIV_IDLE;
                end
            end
            default: begin
                n_state = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= DIV_IDLE;
            r_out_width  <= DIM_W'(OUT_WIDTH_RESET);
            r_out_height <= DIM_W'(OUT_HEIGHT_RESET);
            r_fmt        <= FMT_ARGB8888;
            r_sx         <= DIV_W'(SX_RESET);
            r_sy         <= DIV_W'(SY_RESET);
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_out_width  <= n_out_width;
            r_out_height <= n_out_height;
            r_fmt        <= n_fmt;
            r_sx         <= n_sx;
            r_sy         <= n_sy;
            r_cnt        <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    // Clamp coordinates and scale to source positions
    assign ox_c = ({1'b0, i_ox} >= w_eff) ? w_m1[XY_W-1:0] : i_ox;
    assign oy_c = ({1'b0, i_oy} >= h_eff) ? h_m1[XY_W-1:0] : i_oy;
    assign prod_x = {{DIV_W{1'b0}}, ox_c} * {{XY_W{1'b0}}, r_sx};
    assign prod_y = {{DIV_W{1'b0}}, oy_c} * {{XY_W{1'b0}}, r_sy};

    // Classify the incoming item
    always_comb begin
        n_item.cmd = t_cmd'(i_cmd);
        n_item.sel = i_sel;
        n_item.pix = i_pix;
        n_item.ex  = prod_x[FRAC_BITS-1:0];
        n_item.ey  = prod_y[FRAC_BITS-1:0];
        n_item.iy  = prod_y[FRAC_BITS +: ROW_W];
        if (t_cmd'(i_cmd) == CMD_LOAD) begin
            n_item.col = i_col[ADDR_W-1:0];
            keep       = (32'(i_col) < 32'(SRC_WIDTH));
        end else begin
            n_item.col = prod_x[FRAC_BITS +: ADDR_W];
            keep       = 1'b1;
        end
    end

    // Output stage towards the queue; loads past the line end are dropped
    assign o_ready = (r_state == DIV_IDLE) && (!r_f_valid || !i_full);
    assign accept  = i_valid && o_ready;
    assign o_push  = r_f_valid && !i_full;
    assign o_item  = r_f_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (accept) begin
            r_f_valid <= keep;
        end else if (!i_full) begin
            r_f_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f_item <= n_item;
        end
    end

endmodule

### design/bsp_back.sv
module bsp_back
    import bsp_pkg::*;
    (
        input  logic                 i_clk,
        input  logic                 i_rst_n,
        // from the queue
        input  t_item                i_item,
        input  logic                 i_empty,
        output logic                 o_pop,
        input  t_pix_fmt             i_fmt,
        // result output
        output logic                 o_valid,
        input  logic                 i_ready,
        output logic [WORD_W-1:0]    o_pixel,
        output logic [ROW_W-1:0]     o_row
    );

    localparam int L_RB_U = 0;
    localparam int L_RB_L = 1;
    localparam int L_G_U  = 2;
    localparam int L_G_L  = 3;
    localparam int LANES  = 4;
    localparam int L_RB   = 0;
    localparam int L_G    = 1;

    logic                 adv;
    logic                 is_load;
    logic                 we_u, we_l;
    logic [ADDR_W-1:0]    raddr_b;
    logic [PIX_W-1:0]     c00, c01, c10, c11;

    logic                 r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_out_valid;
    logic [FRAC_BITS-1:0] r_ex1, r_ex2;
    logic [FRAC_BITS-1:0] r_ey1, r_ey2, r_ey3, r_ey4, r_ey5;
    logic [ROW_W-1:0]     r_iy1, r_iy2, r_iy3, r_iy4, r_iy5, r_iy6, r_out_row;
    logic [WORD_W-1:0]    r_a2 [LANES];
    logic [WORD_W-1:0]    r_d2 [LANES];
    logic [WORD_W-1:0]    r_a3 [LANES];
    logic [WORD_W-1:0]    r_p3 [LANES];
    logic [WORD_W-1:0]    r_t4 [LANES];
    logic [WORD_W-1:0]    r_a5 [2];
    logic [WORD_W-1:0]    r_d5 [2];
    logic [WORD_W-1:0]    r_a6 [2];
    logic [WORD_W-1:0]    r_p6 [2];
    logic [WORD_W-1:0]    r_out_pixel;

    logic [WORD_W-1:0]    a_in [LANES];
    logic [WORD_W-1:0]    b_in [LANES];
    logic [WORD_W-1:0]    mask [LANES];
    logic [WORD_W-1:0]    t_nx [LANES];
    logic [WORD_W-1:0]    rb, gw;
    logic [7:0]           red, grn, blu;
    logic [WORD_W-1:0]    packed_pix;

    // Whole back pipeline moves together, held by the output register
    assign adv     = !r_out_valid || i_ready;
    assign o_pop   = adv && !i_empty;
    assign is_load = (i_item.cmd == CMD_LOAD);
    assign we_u    = o_pop && is_load && !i_item.sel;
    assign we_l    = o_pop && is_load && i_item.sel;
    assign raddr_b = i_item.col + ADDR_W'(1);

    // Line stores: loads write, requests read columns ix and ix+1
    bsp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (SRC_WIDTH)
    ) u_upper (
        .i_clk     (i_clk),
        .i_we      (we_u),
        .i_waddr   (i_item.col),
        .i_wdata   (i_item.pix),
        .i_re      (adv),
        .i_raddr_a (i_item.col),
        .i_raddr_b (raddr_b),
        .o_rdata_a (c00),
        .o_rdata_b (c01)
    );

    bsp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (SRC_WIDTH)
    ) u_lower (
        .i_clk     (i_clk),
        .i_we      (we_l),
        .i_waddr   (i_item.col),
        .i_wdata   (i_item.pix),
        .i_re      (adv),
        .i_raddr_a (i_item.col),
        .i_raddr_b (raddr_b),
        .o_rdata_a (c10),
        .o_rdata_b (c11)
    );

    // Split the four neighbours into red/blue and green lanes
    always_comb begin
        mask[L_RB_U] = MASK_RB;
        mask[L_RB_L] = MASK_RB;
        mask[L_G_U]  = MASK_G;
        mask[L_G_L]  = MASK_G;
        a_in[L_RB_U] = WORD_W'(c00) & MASK_RB;
        b_in[L_RB_U] = WORD_W'(c01) & MASK_RB;
        a_in[L_RB_L] = WORD_W'(c10) & MASK_RB;
        b_in[L_RB_L] = WORD_W'(c11) & MASK_RB;
        a_in[L_G_U]  = WORD_W'(c00) & MASK_G;
        b_in[L_G_U]  = WORD_W'(c01) & MASK_G;
        a_in[L_G_L]  = WORD_W'(c10) & MASK_G;
        b_in[L_G_L]  = WORD_W'(c11) & MASK_G;
        for (int k = 0; k < LANES; k++) begin
            t_nx[k] = ((r_p3[k] >> FRAC_BITS) + r_a3[k]) & mask[k];
        end
    end

    // Final vertical step and format packing
    always_comb begin
        rb  = (r_p6[L_RB] >> FRAC_BITS) + r_a6[L_RB];
        gw  = (r_p6[L_G] >> FRAC_BITS) + r_a6[L_G];
        red = rb[23:16];
        blu = rb[7:0];
        grn = gw[15:8];
        unique case (i_fmt)
            FMT_ARGB8888: packed_pix = {8'hFF, red, grn, blu};
            FMT_RGB888:   packed_pix = {8'h00, red, grn, blu};
            FMT_RGB565:   packed_pix = {16'h0000, red[7:3], grn[7:2], blu[7:3]};
            FMT_RGB555:   packed_pix = {16'h0000, 1'b1, red[7:3], grn[7:3], blu[7:3]};
            default:      packed_pix = '0;
        endcase
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_v6        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_v1        <= o_pop && !is_load;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_v6        <= r_v5;
            r_out_valid <= r_v6;
        end
    end

    // Datapath stages: diff, multiply, accumulate; twice
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ex1 <= i_item.ex;
            r_ey1 <= i_item.ey;
            r_iy1 <= i_item.iy;

            r_ex2 <= r_ex1;
            r_ey2 <= r_ey1;
            r_iy2 <= r_iy1;
            for (int k = 0; k < LANES; k++) begin
                r_a2[k] <= a_in[k];
                r_d2[k] <= b_in[k] - a_in[k];
            end

            r_ey3 <= r_ey2;
            r_iy3 <= r_iy2;
            for (int k = 0; k < LANES; k++) begin
                r_a3[k] <= r_a2[k];
                r_p3[k] <= WORD_W'(r_d2[k] * WORD_W'(r_ex2));
            end

            r_ey4 <= r_ey3;
            r_iy4 <= r_iy3;
            for (int k = 0; k < LANES; k++) begin
                r_t4[k] <= t_nx[k];
            end

            r_ey5       <= r_ey4;
            r_iy5       <= r_iy4;
            r_a5[L_RB]  <= r_t4[L_RB_U];
            r_d5[L_RB]  <= r_t4[L_RB_L] - r_t4[L_RB_U];
            r_a5[L_G]   <= r_t4[L_G_U];
            r_d5[L_G]   <= r_t4[L_G_L] - r_t4[L_G_U];

            r_iy6       <= r_iy5;
            for (int j = 0; j < 2; j++) begin
                r_a6[j] <= r_a5[j];
                r_p6[j] <= WORD_W'(r_d5[j] * WORD_W'(r_ey5));
            end

            r_out_pixel <= packed_pix;
            r_out_row   <= r_iy6;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_out_pixel;
    assign o_row   = r_out_row;

endmodule

### design/bilinear_scaler_pixel_packer.sv
// Bilinear scaler with pixel packer. Load transfers (tuser cmd = 0) write a
// 24-bit RGB pixel into the upper or lower line store; request transfers
// (cmd = 1) return one interpolated pixel packed as ARGB8888, RGB888,
// RGB565 or RGB555 together with the upper source row it needs. Loads give
// no result. Items are taken one per clock and results leave one per clock
// when the output is not stalled; a request passes through the front
// scaling stage, the queue, the registered line store read and the six-stage
// interpolation pipe. A queue of four items between the front and the
// interpolation pipe lets the input keep flowing while the output stalls.
// Writing out_width or out_height starts a scale recompute in a shared
// one-bit-per-cycle divider, during which the input and the configuration
// port hold ready low. Store entries must be loaded before a request reads
// them.
module bilinear_scaler_pixel_packer
    import bsp_pkg::*;
    (
        input  logic                  i_clk,
        input  logic                  i_rst_n,
        // input stream
        input  logic                  i_s_tvalid,
        output logic                  o_s_tready,
        input  logic [S_TDATA_W-1:0]  i_s_tdata,  // column, source_pixel, out_x, out_y
        input  logic [S_TUSER_W-1:0]  i_s_tuser,  // cmd, line_select
        // output stream
        output logic                  o_m_tvalid,
        input  logic                  i_m_tready,
        output logic [M_TDATA_W-1:0]  o_m_tdata,  // out_pixel, source_row
        // configuration writes
        input  logic                  i_cfg_valid,
        output logic                  o_cfg_ready,
        input  logic [CFG_IDX_W-1:0]  i_cfg_index,
        input  logic [CFG_DATA_W-1:0] i_cfg_data
    );

    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    t_item             f_item;
    t_item             q_item;
    t_pix_fmt          fmt;
    logic [WORD_W-1:0] pixel;
    logic [ROW_W-1:0]  row;

    // Front: register writes, scale divider, clamp and position scaling
    bsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_cmd       (i_s_tuser[TU_CMD]),
        .i_sel       (i_s_tuser[TU_SEL]),
        .i_col       (i_s_tdata[TD_COL_LSB +: COLUMN_W]),
        .i_pix       (i_s_tdata[TD_PIX_LSB +: PIX_W]),
        .i_ox        (i_s_tdata[TD_OX_LSB +: XY_W]),
        .i_oy        (i_s_tdata[TD_OY_LSB +: XY_W]),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_item      (f_item),
        .i_full      (full),
        .o_fmt       (fmt)
    );

    bsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (q_item),
        .o_empty (empty)
    );

    // Back: line stores, interpolation and packing
    bsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (q_item),
        .i_empty (empty),
        .o_pop   (pop),
        .i_fmt   (fmt),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_pixel (pixel),
        .o_row   (row)
    );

    assign o_m_tdata = {{(M_TDATA_W - WORD_W - ROW_W){1'b0}}, row, pixel};

endmodule

### verif/tb_bilinear_scaler_pixel_packer.sv
`timescale 1ns / 1ps

module tb_bilinear_scaler_pixel_packer;
    import bsp_pkg::*;

    // Unused register index, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int ITEMS_PER_SETTING = 170;
    localparam int SETTINGS_COUNT = 6;

    typedef struct packed {
        logic [WORD_W-1:0] pixel;
        logic [ROW_W-1:0]  row;
    } t_scaled_pixel;

    // Line stores, registers and the queue of pixels still to come out
    class scaler_checker;
        logic [PIX_W-1:0]  upper_store [SRC_WIDTH];
        logic [PIX_W-1:0]  lower_store [SRC_WIDTH];
        logic [DIM_W-1:0]  width_reg;
        logic [DIM_W-1:0]  height_reg;
        t_pix_fmt          format_reg;
        t_scaled_pixel     pending_pixels [$];
        int                mismatches;

        function new();
            foreach (upper_store[i]) begin
                upper_store[i] = '0;
                lower_store[i] = '0;
            end
            width_reg  = DIM_W'(OUT_WIDTH_RESET);
            height_reg = DIM_W'(OUT_HEIGHT_RESET);
            format_reg = FMT_ARGB8888;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_OUT_WIDTH:    width_reg = value;
                CFG_OUT_HEIGHT:   height_reg = value;
                CFG_PIXEL_FORMAT: format_reg = t_pix_fmt'(value[FMT_W-1:0]);
                default: ;
            endcase
        endfunction

        // a + ((b - a) * f >> FRAC_BITS), wrapping at 32 bits
        function bit [31:0] blend(bit [31:0] a, bit [31:0] b, bit [31:0] f);
            return (((b - a) * f) >> FRAC_BITS) + a;
        endfunction

        function bit [31:0] store_word(bit lower, bit [31:0] idx);
            if (idx >= SRC_WIDTH)
                return 32'd0;
            return lower ? 32'(lower_store[idx[ADDR_W-1:0]])
                         : 32'(upper_store[idx[ADDR_W-1:0]]);
        endfunction

        function t_scaled_pixel interpolate(logic [XY_W-1:0] x, logic [XY_W-1:0] y);
            bit [31:0] w, h, ox, oy, sx, sy, fx, fy, ix, iy, ex, ey;
            bit [31:0] c00, c01, c10, c11, t1, t2, rb, gw;
            logic [7:0] r, g, b;
            t_scaled_pixel res;
            // zero size counts as one, coordinates clamp to the last pixel
            w  = (width_reg == 0) ? 32'd1 : 32'(width_reg);
            h  = (height_reg == 0) ? 32'd1 : 32'(height_reg);
            ox = 32'(x);
            oy = 32'(y);
            if (ox >= w)
                ox = w - 1;
            if (oy >= h)
                oy = h - 1;
            sx = 32'((SRC_WIDTH - 1) << FRAC_BITS) / w;
            sy = 32'((SRC_HEIGHT - 1) << FRAC_BITS) / h;
            fx = ox * sx;
            fy = oy * sy;
            ix = fx >> FRAC_BITS;
            iy = fy >> FRAC_BITS;
            ex = fx & ((32'd1 << FRAC_BITS) - 1);
            ey = fy & ((32'd1 << FRAC_BITS) - 1);
            c00 = store_word(1'b0, ix);
            c01 = store_word(1'b0, ix + 1);
            c10 = store_word(1'b1, ix);
            c11 = store_word(1'b1, ix + 1);
            // red and blue share one word, green goes alone
            t1 = blend(c00 & MASK_RB, c01 & MASK_RB, ex) & MASK_RB;
            t2 = blend(c10 & MASK_RB, c11 & MASK_RB, ex) & MASK_RB;
            rb = blend(t1, t2, ey);
            t1 = blend(c00 & MASK_G, c01 & MASK_G, ex) & MASK_G;
            t2 = blend(c10 & MASK_G, c11 & MASK_G, ex) & MASK_G;
            gw = blend(t1, t2, ey);
            r = rb[23:16];
            g = gw[15:8];
            b = rb[7:0];
            case (format_reg)
                FMT_ARGB8888: res.pixel = {8'hFF, r, g, b};
                FMT_RGB888:   res.pixel = {8'h00, r, g, b};
                FMT_RGB565:   res.pixel = {16'h0000, r[7:3], g[7:2], b[7:3]};
                default:      res.pixel = {16'h0000, 1'b1, r[7:3], g[7:3], b[7:3]};
            endcase
            res.row = iy[ROW_W-1:0];
            return res;
        endfunction

        function void take_item(t_cmd cmd, logic sel, logic [COLUMN_W-1:0] col,
                                logic [PIX_W-1:0] pix, logic [XY_W-1:0] ox,
                                logic [XY_W-1:0] oy);
            if (cmd == CMD_LOAD) begin
                // columns past the store are dropped
                if (col < SRC_WIDTH) begin
                    if (sel)
                        lower_store[col] = pix;
                    else
                        upper_store[col] = pix;
                end
            end else begin
                pending_pixels.push_back(interpolate(ox, oy));
            end
        endfunction

        function void report(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
        endfunction

        function void check_pixel(logic [WORD_W-1:0] pixel, logic [ROW_W-1:0] row);
            t_scaled_pixel want;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected result, expected none, actual %h row %h",
                         $time, pixel, row);
                return;
            end
            want = pending_pixels.pop_front();
            if (want.pixel !== pixel)
                report("out_pixel", want.pixel, pixel);
            if (want.row !== row)
                report("source_row", 32'(want.row), 32'(row));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata = '0;
    logic [S_TUSER_W-1:0]  i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int send_idle_pct = 17;
    int recv_stall_pct = 61;
    scaler_checker board;

    bilinear_scaler_pixel_packer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Random back-pressure on the result stream
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every result transfer is checked against the oldest expected pixel
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_pixel(o_m_tdata[WORD_W-1:0], o_m_tdata[WORD_W +: ROW_W]);
    end

    task automatic send_item(input t_cmd cmd, input logic sel, input logic [COLUMN_W-1:0] col,
                             input logic [PIX_W-1:0] pix, input logic [XY_W-1:0] ox,
                             input logic [XY_W-1:0] oy);
        logic [S_TDATA_W-1:0] word;
        logic [S_TUSER_W-1:0] user;
        word = '0;
        word[TD_COL_LSB +: COLUMN_W] = col;
        word[TD_PIX_LSB +: PIX_W]    = pix;
        word[TD_OX_LSB +: XY_W]      = ox;
        word[TD_OY_LSB +: XY_W]      = oy;
        user = '0;
        user[TU_CMD] = cmd;
        user[TU_SEL] = sel;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        i_s_tuser  <= user;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        board.take_item(cmd, sel, col, pix, ox, oy);
    endtask

    // Unused fields of each kind of item carry random bits
    task automatic send_load(input logic sel, input logic [COLUMN_W-1:0] col,
                             input logic [PIX_W-1:0] pix);
        send_item(CMD_LOAD, sel, col, pix, XY_W'($urandom), XY_W'($urandom));
    endtask

    task automatic send_request(input logic [XY_W-1:0] ox, input logic [XY_W-1:0] oy);
        send_item(CMD_REQUEST, 1'($urandom), COLUMN_W'($urandom), PIX_W'($urandom), ox, oy);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        board.set_register(idx, value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending until every pixel is out, then allow for loads in flight
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly inside the output size, sometimes anywhere so that clamping is hit
    function automatic logic [XY_W-1:0] pick_coord(logic [DIM_W-1:0] size);
        int unsigned lim;
        lim = (size == 0) ? 0 : size - 1;
        if (lim > 4095)
            lim = 4095;
        if ($urandom_range(3) != 0)
            return XY_W'($urandom_range(lim));
        return XY_W'($urandom_range(4095));
    endfunction

    task automatic random_items(input int count);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2)
                settle();
            if ($urandom_range(99) < 40) begin
                if ($urandom_range(9) == 0)
                    send_load(1'($urandom), COLUMN_W'($urandom_range(1023)), PIX_W'($urandom));
                else
                    send_load(1'($urandom), COLUMN_W'($urandom_range(SRC_WIDTH - 1)),
                              PIX_W'($urandom));
            end else begin
                send_request(pick_coord(board.width_reg), pick_coord(board.height_reg));
            end
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] w, h;
        t_pix_fmt fmt;
        board = new();
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unknown index leaves the reset settings alone
        write_register(CFG_UNUSED, CFG_DATA_W'($urandom));

        // fill both line stores so that no request reads an empty entry
        for (int c = 0; c < SRC_WIDTH; c++) begin
            send_load(1'b0, COLUMN_W'(c), PIX_W'($urandom));
            send_load(1'b1, COLUMN_W'(c), PIX_W'($urandom));
        end

        // directed: full-scale colours across the first cell, edges, clamping
        send_load(1'b0, 10'd0, 24'hFFFFFF);
        send_load(1'b0, 10'd1, 24'h000000);
        send_load(1'b1, 10'd0, 24'h000000);
        send_load(1'b1, 10'd1, 24'hFFFFFF);
        send_load(1'b0, 10'd1023, 24'h123456);
        send_load(1'b1, 10'd640, 24'hFEDCBA);
        send_load(1'b0, 10'd639, 24'hFFFFFF);
        send_load(1'b1, 10'd638, 24'h000000);
        send_request(12'd0, 12'd0);
        send_request(12'd1, 12'd0);
        send_request(12'd1, 12'd1);
        send_request(12'd0, 12'd1);
        send_request(12'd639, 12'd399);
        send_request(12'd640, 12'd400);
        send_request(12'd4095, 12'd4095);
        send_request(12'd320, 12'd200);
        send_request(12'd638, 12'd398);

        for (int s = 0; s < SETTINGS_COUNT; s++) begin
            case (s / 2)
                0: begin
                    send_idle_pct  = 17;
                    recv_stall_pct = 61;
                end
                1: begin
                    send_idle_pct  = 61;
                    recv_stall_pct = 17;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            case (s)
                0: begin
                    w = 13'd1;
                    h = 13'd1;
                    fmt = FMT_RGB565;
                end
                1: begin
                    w = 13'd4096;
                    h = 13'd4096;
                    fmt = FMT_RGB888;
                end
                2: begin
                    w = 13'd0;
                    h = 13'd8191;
                    fmt = FMT_RGB555;
                end
                3: begin
                    w = CFG_DATA_W'($urandom_range(4096, 1));
                    h = CFG_DATA_W'($urandom_range(4096, 1));
                    fmt = FMT_ARGB8888;
                end
                4: begin
                    w = 13'd8191;
                    h = 13'd0;
                    fmt = FMT_RGB565;
                end
                default: begin
                    w = CFG_DATA_W'($urandom_range(700, 1));
                    h = CFG_DATA_W'($urandom_range(450, 1));
                    fmt = t_pix_fmt'($urandom_range(3));
                end
            endcase
            settle();
            write_register(CFG_OUT_WIDTH, w);
            write_register(CFG_OUT_HEIGHT, h);
            write_register(CFG_PIXEL_FORMAT, CFG_DATA_W'(fmt));
            random_items(ITEMS_PER_SETTING);
        end

        settle();
        if (board.mismatches == 0 && board.pending_pixels.size() == 0)
            $display("bilinear_scaler_pixel_packer regression: pass");
        else
            $display("bilinear_scaler_pixel_packer regression: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("bilinear_scaler_pixel_packer regression: fail");
        $finish;
    end

endmodule
